// ===== hw/rtl/d96gt_pkg.sv =====
// shared types, widths and the power-of-ten table for the decimal96 compare pipeline
// no dependencies
package d96gt_pkg;

    localparam int MANT_W    = 96;
    localparam int LOW_W     = 64;
    localparam int HIGH_W    = 32;
    localparam int SCALE_W   = 5;
    localparam int MAX_SCALE = 28;
    localparam int POW_W     = 94;
    localparam int PROD_W    = 190;
    localparam int LIMB_W    = 32;
    localparam int LIMBS     = MANT_W / LIMB_W;
    localparam int PP_W      = 2 * LIMB_W;
    localparam int ROW_W     = MANT_W + LIMB_W;
    localparam int SUM_W     = ROW_W + 2 * LIMB_W;

    typedef logic [MANT_W-1:0]  mant_t;
    typedef logic [POW_W-1:0]   pow_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [SCALE_W-1:0] scale_t;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic sign_diff;
        logic negative;
        logic swap;
    } ctl_t;

    function automatic scale_t clamp_scale(input scale_t s);
        if (s > scale_t'(MAX_SCALE)) begin
            return scale_t'(MAX_SCALE);
        end
        return s;
    endfunction

    function automatic pow_t pow10(input scale_t d);
        pow_t p;
        case (d)
            5'd0:    p = 94'd1;
            5'd1:    p = 94'd10;
            5'd2:    p = 94'd100;
            5'd3:    p = 94'd1000;
            5'd4:    p = 94'd10000;
            5'd5:    p = 94'd100000;
            5'd6:    p = 94'd1000000;
            5'd7:    p = 94'd10000000;
            5'd8:    p = 94'd100000000;
            5'd9:    p = 94'd1000000000;
            5'd10:   p = 94'd10000000000;
            5'd11:   p = 94'd100000000000;
            5'd12:   p = 94'd1000000000000;
            5'd13:   p = 94'd10000000000000;
            5'd14:   p = 94'd100000000000000;
            5'd15:   p = 94'd1000000000000000;
            5'd16:   p = 94'd10000000000000000;
            5'd17:   p = 94'd100000000000000000;
            5'd18:   p = 94'd1000000000000000000;
            5'd19:   p = 94'd10000000000000000000;
            5'd20:   p = 94'd100000000000000000000;
            5'd21:   p = 94'd1000000000000000000000;
            5'd22:   p = 94'd10000000000000000000000;
            5'd23:   p = 94'd100000000000000000000000;
            5'd24:   p = 94'd1000000000000000000000000;
            5'd25:   p = 94'd10000000000000000000000000;
            5'd26:   p = 94'd100000000000000000000000000;
            5'd27:   p = 94'd1000000000000000000000000000;
            5'd28:   p = 94'd10000000000000000000000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/d96gt_align.sv =====
// stage 1: scale clamp, scale difference, operand swap and power-of-ten lookup
// depends on d96gt_pkg
module d96gt_align (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [63:0]            a_mant_low,
    input  logic [31:0]            a_mant_high,
    input  logic [4:0]             a_scale,
    input  logic                   a_negative,
    input  logic [63:0]            b_mant_low,
    input  logic [31:0]            b_mant_high,
    input  logic [4:0]             b_scale,
    input  logic                   b_negative,
    output d96gt_pkg::mant_t       x,
    output d96gt_pkg::mant_t       y,
    output d96gt_pkg::pow_t        pw,
    output d96gt_pkg::ctl_t        ctl
);
    import d96gt_pkg::*;

    scale_t sa;
    scale_t sb;
    scale_t diff;
    mant_t  ma;
    mant_t  mb;
    ctl_t   ctl_reg;
    ctl_t   ctl_next;
    mant_t  x_reg;
    mant_t  x_next;
    mant_t  y_reg;
    mant_t  y_next;
    pow_t   pw_reg;
    pow_t   pw_next;

    always_comb
    begin
        sa = clamp_scale(a_scale);
        sb = clamp_scale(b_scale);
        ma = {a_mant_high, a_mant_low};
        mb = {b_mant_high, b_mant_low};
        // the operand with the smaller scale is the one that gets multiplied
        ctl_next.valid     = start;
        ctl_next.sign_diff = a_negative ^ b_negative;
        ctl_next.negative  = a_negative;
        ctl_next.swap      = (sb < sa);
        diff    = ctl_next.swap ? (sa - sb) : (sb - sa);
        x_next  = ctl_next.swap ? mb : ma;
        y_next  = ctl_next.swap ? ma : mb;
        pw_next = pow10(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        y_reg  <= y_next;
        pw_reg <= pw_next;
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign pw  = pw_reg;
    assign ctl = ctl_reg;

endmodule

// ===== hw/rtl/d96gt_mul.sv =====
// stages 2 to 4: 96 x 94 bit multiply as nine 32 x 32 partial products,
// row sums, then the final 190-bit sum; depends on d96gt_pkg
module d96gt_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  d96gt_pkg::mant_t       x,
    input  d96gt_pkg::mant_t       y_in,
    input  d96gt_pkg::pow_t        pw,
    input  d96gt_pkg::ctl_t        ctl_in,
    output d96gt_pkg::prod_t       prod,
    output d96gt_pkg::mant_t       y_out,
    output d96gt_pkg::ctl_t        ctl_out
);
    import d96gt_pkg::*;

    logic [MANT_W-1:0] pw_ext;
    logic [PP_W-1:0]   pp_reg   [LIMBS][LIMBS];
    logic [PP_W-1:0]   pp_next  [LIMBS][LIMBS];
    logic [ROW_W-1:0]  row_reg  [LIMBS];
    logic [ROW_W-1:0]  row_next [LIMBS];
    logic [SUM_W-1:0]  sum;
    prod_t             prod_reg;
    prod_t             prod_next;
    mant_t             y2_reg;
    mant_t             y3_reg;
    mant_t             y4_reg;
    ctl_t              ctl2_reg;
    ctl_t              ctl3_reg;
    ctl_t              ctl4_reg;

    assign pw_ext = MANT_W'(pw);

    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            for (int j = 0; j < LIMBS; j++)
            begin
                pp_next[i][j] = PP_W'(x[i*LIMB_W +: LIMB_W]) * PP_W'(pw_ext[j*LIMB_W +: LIMB_W]);
            end
        end
    end

    // row i is x limb i times the whole power; fits in 128 bits since 10^28 < 2^94
    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            row_next[i] = ROW_W'(pp_reg[i][0])
                        + (ROW_W'(pp_reg[i][1]) << LIMB_W)
                        + (ROW_W'(pp_reg[i][2]) << (2 * LIMB_W));
        end
    end

    always_comb
    begin
        sum = SUM_W'(row_reg[0])
            + (SUM_W'(row_reg[1]) << LIMB_W)
            + (SUM_W'(row_reg[2]) << (2 * LIMB_W));
        prod_next = sum[PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl_in;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg   <= pp_next;
        row_reg  <= row_next;
        prod_reg <= prod_next;
        y2_reg   <= y_in;
        y3_reg   <= y2_reg;
        y4_reg   <= y3_reg;
    end

    assign prod    = prod_reg;
    assign y_out   = y4_reg;
    assign ctl_out = ctl4_reg;

endmodule

// ===== hw/rtl/d96gt_cmp.sv =====
// stage 5: magnitude compare, sign handling and the result register
// depends on d96gt_pkg
module d96gt_cmp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  d96gt_pkg::prod_t       prod,
    input  d96gt_pkg::mant_t       y,
    input  d96gt_pkg::ctl_t        ctl,
    output logic                   done,
    output logic                   a_greater
);
    import d96gt_pkg::*;

    prod_t y_ext;
    logic  prod_gt;
    logic  prod_lt;
    logic  a_mag_gt;
    logic  a_mag_lt;
    logic  done_reg;
    logic  done_next;
    logic  a_greater_reg;
    logic  a_greater_next;

    always_comb
    begin
        y_ext    = PROD_W'(y);
        prod_gt  = (prod > y_ext);
        prod_lt  = (prod < y_ext);
        // with swap the scaled product belongs to b
        a_mag_gt = ctl.swap ? prod_lt : prod_gt;
        a_mag_lt = ctl.swap ? prod_gt : prod_lt;
        if (ctl.sign_diff)
        begin
            a_greater_next = !ctl.negative;
        end
        else
        begin
            a_greater_next = ctl.negative ? a_mag_lt : a_mag_gt;
        end
        done_next = ctl.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_greater_reg <= a_greater_next;
    end

    assign done      = done_reg;
    assign a_greater = a_greater_reg;

endmodule

// ===== hw/rtl/decimal96_greater_than_core.sv =====
// top level of the decimal96 strict greater-than compare
// depends on d96gt_pkg, d96gt_align, d96gt_mul, d96gt_cmp

// Five-stage pipeline: a transfer is taken on every cycle that start is high,
// busy never rises, and the answer for each transfer shows on a_greater with
// done high from the compare register, one result per transfer in order.
// The latency is set by the 96 x 94 bit scaling multiply, which is split into
// 32 x 32 partial products, row sums and a final sum before the compare.
// Scales above 28 are treated as 28. The receiver cannot stall.
module decimal96_greater_than_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] a_mant_low,
    input  logic [31:0] a_mant_high,
    input  logic [4:0]  a_scale,
    input  logic        a_negative,
    input  logic [63:0] b_mant_low,
    input  logic [31:0] b_mant_high,
    input  logic [4:0]  b_scale,
    input  logic        b_negative,
    output logic        done,
    output logic        a_greater
);
    import d96gt_pkg::*;

    mant_t x1;
    mant_t y1;
    pow_t  pw1;
    ctl_t  ctl1;
    prod_t prod4;
    mant_t y4;
    ctl_t  ctl4;

    assign busy = 1'b0;

    d96gt_align u_align (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .a_mant_low  (a_mant_low),
        .a_mant_high (a_mant_high),
        .a_scale     (a_scale),
        .a_negative  (a_negative),
        .b_mant_low  (b_mant_low),
        .b_mant_high (b_mant_high),
        .b_scale     (b_scale),
        .b_negative  (b_negative),
        .x           (x1),
        .y           (y1),
        .pw          (pw1),
        .ctl         (ctl1)
    );

    d96gt_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .x       (x1),
        .y_in    (y1),
        .pw      (pw1),
        .ctl_in  (ctl1),
        .prod    (prod4),
        .y_out   (y4),
        .ctl_out (ctl4)
    );

    d96gt_cmp u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .prod      (prod4),
        .y         (y4),
        .ctl       (ctl4),
        .done      (done),
        .a_greater (a_greater)
    );

endmodule

// ===== hw/rtl/d96gt_chk.sv =====
// port-level checks for decimal96_greater_than_core, bound to the top level
// depends on decimal96_greater_than_core through the bind below
module d96gt_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] a_mant_low,
    input logic [31:0] a_mant_high,
    input logic [4:0]  a_scale,
    input logic        a_negative,
    input logic [63:0] b_mant_low,
    input logic [31:0] b_mant_high,
    input logic [4:0]  b_scale,
    input logic        b_negative,
    input logic        done,
    input logic        a_greater
);

    // every transfer gets its answer, with done high, at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 done)
        else $error("missing result five cycles after transfer");

    // no result without a transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##5 !done)
        else $error("result without a transfer");

    // differing signs: the sign alone decides
    a_sign_rule: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (a_negative != b_negative) |-> ##5 (a_greater != $past(a_negative, 5)))
        else $error("sign rule broken");

    // identical operands are never greater
    a_equal: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (a_mant_low == b_mant_low) && (a_mant_high == b_mant_high)
        && (a_scale == b_scale) && (a_negative == b_negative) |-> ##5 !a_greater)
        else $error("equal operands reported greater");

endmodule

bind decimal96_greater_than_core d96gt_chk u_chk (.*);
